// ===== rtl/sbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfp_pkg
// Shared types, constants and helpers of the seven-bit serial frame packer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbfp_pkg;

  // framing markers and data flag
  localparam logic [7:0] MarkOpen  = 8'h00;
  localparam logic [7:0] MarkClose = 8'h02;
  localparam logic       DataFlag  = 1'b1;

  // bits carried by one data byte on the link
  localparam int unsigned GroupBits = 7;

  // most results one input item can cause
  localparam int unsigned MaxRes = 3;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  // input commands
  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } sbfp_cmd_e;

  // packer state carried between items
  typedef struct packed {
    logic [GroupBits-1:0] bits;
    logic [2:0]           count;
    logic                 frame_open;
  } sbfp_state_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
  } sbfp_res_t;

  typedef sbfp_res_t [MaxRes-1:0] sbfp_res_arr_t;

  // mask with the k lowest bits set, k in 0..7
  function automatic logic [GroupBits-1:0] low_mask(input logic [2:0] k);
    logic [GroupBits:0] m;
    m = (8'(1) << k) - 8'(1);
    return m[GroupBits-1:0];
  endfunction

  // 7-bit group as a link data byte
  function automatic sbfp_res_t data_group(input logic [GroupBits-1:0] g);
    sbfp_res_t r;
    r.out_byte   = {g, DataFlag};
    r.frame_last = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sbfp_in_if.sv =====
// ----------------------------------------------------------------------------
// sbfp_in_if
// Input channel of the frame packer: command and payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbfp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sbfp_out_if.sv =====
// ----------------------------------------------------------------------------
// sbfp_out_if
// Output channel of the frame packer: framed link byte and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_last;

  modport source (output valid, output out_byte, output frame_last, input ready);
  modport sink   (input valid, input out_byte, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/sbfp_pack.sv =====
// ----------------------------------------------------------------------------
// sbfp_pack
// Packing step: turns one command and the current state into up to three
// link bytes and the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfp_pack
  import sbfp_pkg::*;
(
  input  logic                cmd_i,
  input  logic [7:0]          data_byte_i,
  input  sbfp_state_t         state_i,
  output sbfp_state_t         state_o,
  output sbfp_res_arr_t       res_o,
  output logic [ResCntW-1:0]  res_cnt_o
);

  logic [2:0]              cnt;
  logic [2:0]              rem;
  logic [GroupBits-1:0]    kept;
  logic [GroupBits+7:0]    acc;
  logic [GroupBits-1:0]    first_grp;
  logic [GroupBits-1:0]    tail_grp;
  logic [GroupBits-1:0]    pad_grp;

  // datapath for both commands
  always_comb begin
    cnt       = (state_i.count >= 3'(GroupBits)) ? 3'd0 : state_i.count;
    rem       = cnt + 3'd1;
    kept      = state_i.bits & low_mask(cnt);
    acc       = {kept, data_byte_i};
    first_grp = GroupBits'(acc >> rem);
    tail_grp  = acc[GroupBits-1:0] & low_mask(rem);
    pad_grp   = GroupBits'(kept << (3'(GroupBits) - cnt));
  end

  // result list and next state
  always_comb begin
    res_o     = '0;
    res_cnt_o = '0;
    state_o   = state_i;

    // opening marker ahead of the first output of a frame
    if (!state_i.frame_open) begin
      res_o[res_cnt_o] = '{out_byte: MarkOpen, frame_last: 1'b0};
      res_cnt_o        = res_cnt_o + ResCntW'(1);
      state_o.frame_open = 1'b1;
    end

    case (sbfp_cmd_e'(cmd_i))
      CMD_DATA: begin
        res_o[res_cnt_o] = data_group(first_grp);
        res_cnt_o        = res_cnt_o + ResCntW'(1);
        if (rem == 3'(GroupBits)) begin
          // a whole second group is left over
          res_o[res_cnt_o] = data_group(tail_grp);
          res_cnt_o        = res_cnt_o + ResCntW'(1);
          state_o.bits     = '0;
          state_o.count    = '0;
        end else begin
          state_o.bits  = tail_grp;
          state_o.count = rem;
        end
      end
      CMD_END: begin
        // flush leftover bits, zero padded at the low end
        if (cnt != 3'd0) begin
          res_o[res_cnt_o] = data_group(pad_grp);
          res_cnt_o        = res_cnt_o + ResCntW'(1);
        end
        res_o[res_cnt_o] = '{out_byte: MarkClose, frame_last: 1'b1};
        res_cnt_o        = res_cnt_o + ResCntW'(1);
        state_o          = '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/seven_bit_serial_frame_packer_unit.sv =====
// ----------------------------------------------------------------------------
// seven_bit_serial_frame_packer_unit
// Frames a byte stream for a serial link: 7-bit groups with a set low bit,
// opened by marker 0x00 and closed by marker 0x02.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ----------------------------
//  in_i     in   valid / ready  cmd (1), data_byte (8)
//  out_o    out  valid / ready  out_byte (8), frame_last (1)
//
// An item is taken into an input register, packed in one pass into a result
// buffer of up to three bytes, and that buffer drains one byte per cycle while
// out_o is ready. An item yields 1 to 3 link bytes (1 for a typical data
// byte mid-frame). An input transfer passes through the input register and
// then the result buffer on its way to the output.
// The input register takes a new item while the buffer still drains.
// Reset clears the packing state and all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_bit_serial_frame_packer_unit
  import sbfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sbfp_in_if.sink     in_i,
  sbfp_out_if.source  out_o
);

  logic                 in_vld_q;
  logic                 in_cmd_q;
  logic [7:0]           in_byte_q;
  sbfp_state_t          st_q;
  sbfp_state_t          st_d;
  sbfp_res_arr_t        res_q;
  sbfp_res_arr_t        res_d;
  logic [ResCntW-1:0]   res_n_q;
  logic [ResCntW-1:0]   res_n_d;
  logic                 out_take;
  logic                 load;
  logic                 in_take;

  // packing step between input register and result buffer
  sbfp_pack u_pack (
    .cmd_i       (in_cmd_q),
    .data_byte_i (in_byte_q),
    .state_i     (st_q),
    .state_o     (st_d),
    .res_o       (res_d),
    .res_cnt_o   (res_n_d)
  );

  // handshake control
  assign out_take   = (res_n_q != '0) && out_o.ready;
  assign load       = in_vld_q &&
                      ((res_n_q == '0) || ((res_n_q == ResCntW'(1)) && out_o.ready));
  assign in_i.ready = !in_vld_q || load;
  assign in_take    = in_i.valid && in_i.ready;

  // output side
  assign out_o.valid      = (res_n_q != '0);
  assign out_o.out_byte   = res_q[0].out_byte;
  assign out_o.frame_last = res_q[0].frame_last;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      res_n_q  <= '0;
      st_q     <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (load) begin
        in_vld_q <= 1'b0;
      end
      if (load) begin
        res_n_q <= res_n_d;
        st_q    <= st_d;
      end else if (out_take) begin
        res_n_q <= res_n_q - ResCntW'(1);
      end
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q  <= in_i.cmd;
      in_byte_q <= in_i.data_byte;
    end
  end

  // result buffer, head at slot zero
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end else if (out_take) begin
      for (int i = 0; i < int'(MaxRes) - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // buffer never holds more than one item's results
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_n_q <= ResCntW'(MaxRes))
    else $error("result buffer count out of range");

  // leftover count stays below one group
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.count < 3'(GroupBits))
    else $error("leftover count reached a full group");

  // anything but a marker is a data byte with its flag bit set
  a_data_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.out_byte != MarkOpen) && (out_o.out_byte != MarkClose)
    |-> out_o.out_byte[0] == DataFlag)
    else $error("data byte without flag bit");

  // last flag only on the closing marker
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_last |-> out_o.out_byte == MarkClose)
    else $error("frame_last on a byte other than the closing marker");

  // a closing marker leaves the packer with no frame open
  a_close_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (in_cmd_q == CMD_END) |=> !st_q.frame_open && (st_q.count == 3'd0))
    else $error("state not cleared after end of frame");

  // an empty input register always takes a transfer
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_i.ready)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire
